FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, muted while reset is high
`define TSSM_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also watches reset cycles
`define TSSM_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/tssm_pkg.sv
// Shared types and constants of the task stall/slow monitor.
// No dependencies; used by every module of the block.
package tssm_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
  localparam int SLOT_W     = 6;
  localparam int TIME_W     = 63;
  localparam int SCOPE_W    = 64;
  localparam int MS_W       = 44;
  localparam int LIMIT_W    = 32;
  localparam int EV_W       = 2;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int QDEPTH     = 2;

  // Nanoseconds per millisecond
  localparam int               REM_W     = 20;
  localparam logic [REM_W-1:0] NS_PER_MS = REM_W'(1000000);

  // Divide by one million: drop the factor 64, then multiply by
  // ceil(2^71 / 15625) and keep the bits from 71 up
  localparam int                 DIV_PRE_SH = 6;
  localparam int                 DIV_X_W    = TIME_W - DIV_PRE_SH;
  localparam int                 RECIP_W    = 58;
  localparam int                 RECIP_SH   = 71;
  localparam logic [RECIP_W-1:0] RECIP      = 58'd151115727451828647;
  localparam int                 DIV_ACC_W  = DIV_X_W + RECIP_W;
  localparam int                 MUL_W      = 32;

  // Register reset values
  localparam logic [LIMIT_W-1:0] STALL_LIMIT_RST = LIMIT_W'(60000);
  localparam logic [LIMIT_W-1:0] SLOW_LIMIT_RST  = LIMIT_W'(10000);

  // Register select (paddr bit 2)
  localparam logic REG_STALL_LIMIT = 1'b0;
  localparam logic REG_SLOW_LIMIT  = 1'b1;

  typedef enum logic [EV_W-1:0] {
    EV_NONE  = 2'd0,
    EV_STALL = 2'd1,
    EV_SLOW  = 2'd2
  } ev_t;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_CLEAR,
    KIND_TRACK
  } item_kind_t;

  typedef struct packed {
    item_kind_t         kind;
    logic [SLOT_W-1:0]  slot;
    logic [TIME_W-1:0]  start;
    logic [SCOPE_W-1:0] scope;
    logic [TIME_W-1:0]  now;
    logic               stall_exempt;
    logic               slow_exempt;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]  start;
    logic [SCOPE_W-1:0] scope;
    logic [TIME_W-1:0]  progress;
    logic               stall_done;
    logic               slow_done;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_DIVIDE,
    BK_EVENT,
    BK_FINISH
  } back_state_t;

endpackage

FILE: sv/tssm_front.sv
// Front end: accepts observation words and classifies them for the back end.
// Depends on tssm_pkg.
module tssm_front (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tssm_pkg::SLOT_W-1:0]     thread_slot,
  input  logic                            task_active,
  input  logic [tssm_pkg::TIME_W-1:0]     task_start,
  input  logic [tssm_pkg::SCOPE_W-1:0]    scope_tag,
  input  logic [tssm_pkg::TIME_W-1:0]     now_time,
  input  logic                            stall_exempt,
  input  logic                            slow_exempt,
  input  tssm_pkg::q_status_t             q_stat,
  output logic                            push,
  output tssm_pkg::item_t                 push_item
);

  logic slot_ok;

  // Take a word whenever the queue has room
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  // Slots past the table leave the state alone
  assign slot_ok = 32'(thread_slot) < 32'(tssm_pkg::NUM_SLOTS);

  // Classify and pack the word
  always_comb begin
    push_item.slot         = thread_slot;
    push_item.start        = task_start;
    push_item.scope        = scope_tag;
    push_item.now          = now_time;
    push_item.stall_exempt = stall_exempt;
    push_item.slow_exempt  = slow_exempt;
    if (!slot_ok) begin
      push_item.kind = tssm_pkg::KIND_SKIP;
    end else if (!task_active) begin
      push_item.kind = tssm_pkg::KIND_CLEAR;
    end else begin
      push_item.kind = tssm_pkg::KIND_TRACK;
    end
  end

endmodule

FILE: sv/tssm_fifo.sv
// Short queue of classified words between the front and back ends.
// Depends on tssm_pkg.
module tssm_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tssm_pkg::item_t     push_item,
  input  logic                pop,
  output tssm_pkg::item_t     pop_item,
  output tssm_pkg::q_status_t q_stat
);

  localparam int PTR_W = (tssm_pkg::QDEPTH > 1) ? $clog2(tssm_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(tssm_pkg::QDEPTH + 1);

  tssm_pkg::item_t  slots [tssm_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_stat.full  = count == CNT_W'(tssm_pkg::QDEPTH);
  assign q_stat.empty = count == '0;
  assign pop_item     = slots[rd_ptr];

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(tssm_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(tssm_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/tssm_div.sv
// Two-lane divide by one million (ns to whole ms) by reciprocal multiplication.
// Depends on tssm_pkg.
module tssm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tssm_pkg::TIME_W-1:0] dvd_a,
  input  logic [tssm_pkg::TIME_W-1:0] dvd_b,
  output logic                        done,
  output logic [tssm_pkg::MS_W-1:0]   quot_a,
  output logic [tssm_pkg::MS_W-1:0]   quot_b
);

  logic [tssm_pkg::DIV_X_W-1:0]   xa;
  logic [tssm_pkg::DIV_X_W-1:0]   xb;
  logic [tssm_pkg::DIV_ACC_W-1:0] acc_a;
  logic [tssm_pkg::DIV_ACC_W-1:0] acc_b;
  logic [1:0]                     step;
  logic                           busy;
  logic                           x_hi;
  logic                           m_hi;
  logic [tssm_pkg::MUL_W-1:0]     opx_a;
  logic [tssm_pkg::MUL_W-1:0]     opx_b;
  logic [tssm_pkg::MUL_W-1:0]     opm;
  logic [2*tssm_pkg::MUL_W-1:0]   pp_a;
  logic [2*tssm_pkg::MUL_W-1:0]   pp_b;
  logic [6:0]                     pp_sh;
  logic [tssm_pkg::DIV_ACC_W-1:0] add_a;
  logic [tssm_pkg::DIV_ACC_W-1:0] add_b;

  // Four partial products: low/high half of the dividend times low/high half
  // of the reciprocal
  assign x_hi  = step[1];
  assign m_hi  = step[0];
  assign opx_a = x_hi ? tssm_pkg::MUL_W'(xa[tssm_pkg::DIV_X_W-1:tssm_pkg::MUL_W])
                      : xa[tssm_pkg::MUL_W-1:0];
  assign opx_b = x_hi ? tssm_pkg::MUL_W'(xb[tssm_pkg::DIV_X_W-1:tssm_pkg::MUL_W])
                      : xb[tssm_pkg::MUL_W-1:0];
  assign opm   = m_hi ? tssm_pkg::MUL_W'(tssm_pkg::RECIP[tssm_pkg::RECIP_W-1:tssm_pkg::MUL_W])
                      : tssm_pkg::RECIP[tssm_pkg::MUL_W-1:0];

  // 32 x 32 products, weighted by 0, 32 or 64 bits
  assign pp_a  = (2*tssm_pkg::MUL_W)'(opx_a) * (2*tssm_pkg::MUL_W)'(opm);
  assign pp_b  = (2*tssm_pkg::MUL_W)'(opx_b) * (2*tssm_pkg::MUL_W)'(opm);
  assign pp_sh = {x_hi & m_hi, x_hi ^ m_hi, 5'b0};
  assign add_a = tssm_pkg::DIV_ACC_W'(pp_a) << pp_sh;
  assign add_b = tssm_pkg::DIV_ACC_W'(pp_b) << pp_sh;

  // Quotient is the top of the full product
  assign quot_a = acc_a[tssm_pkg::RECIP_SH +: tssm_pkg::MS_W];
  assign quot_b = acc_b[tssm_pkg::RECIP_SH +: tssm_pkg::MS_W];

  // Load dividends, then accumulate one partial product per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      xa    <= dvd_a[tssm_pkg::TIME_W-1:tssm_pkg::DIV_PRE_SH];
      xb    <= dvd_b[tssm_pkg::TIME_W-1:tssm_pkg::DIV_PRE_SH];
      acc_a <= '0;
      acc_b <= '0;
    end else if (busy) begin
      acc_a <= acc_a + add_a;
      acc_b <= acc_b + add_b;
    end
  end

  // Count the steps and flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/tssm_back.sv
// Back end: slot table lookup, progress tracking, event decision, result register.
// Depends on tssm_pkg and tssm_div.
module tssm_back (
  input  logic                         clk,
  input  logic                         rst,
  input  tssm_pkg::item_t              q_item,
  input  tssm_pkg::q_status_t          q_stat,
  output logic                         pop,
  input  logic [tssm_pkg::LIMIT_W-1:0] stall_limit,
  input  logic [tssm_pkg::LIMIT_W-1:0] slow_limit,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tssm_pkg::EV_W-1:0]    event_res,
  output logic [tssm_pkg::SLOT_W-1:0]  slot_out,
  output logic [tssm_pkg::MS_W-1:0]    running_ms,
  output logic [tssm_pkg::MS_W-1:0]    idle_ms,
  output logic                         had_progress
);

  tssm_pkg::back_state_t state;
  tssm_pkg::back_state_t state_next;

  tssm_pkg::entry_t               table_mem [tssm_pkg::NUM_SLOTS];
  tssm_pkg::entry_t               rd_data;
  logic [tssm_pkg::NUM_SLOTS-1:0] entry_valid;

  tssm_pkg::item_t                cur;
  tssm_pkg::entry_t               ent;
  logic                           res_hp;
  tssm_pkg::ev_t                  res_ev;
  logic [tssm_pkg::MS_W-1:0]      res_run;
  logic [tssm_pkg::MS_W-1:0]      res_idle;

  logic [tssm_pkg::SLOT_IDX_W-1:0] q_idx;
  logic [tssm_pkg::SLOT_IDX_W-1:0] cur_idx;

  // Control strobes
  logic mem_re;
  logic mem_we;
  logic div_start;
  logic clr_valid;
  logic out_load;

  // Lookup path
  logic                        hit;
  tssm_pkg::entry_t            ent_new;
  logic [tssm_pkg::TIME_W-1:0] run_diff;
  logic [tssm_pkg::TIME_W-1:0] idle_diff;

  // Event path
  logic                        div_done;
  logic [tssm_pkg::MS_W-1:0]   quot_run;
  logic [tssm_pkg::MS_W-1:0]   quot_idle;
  logic                        stall_hit;
  logic                        slow_hit;
  tssm_pkg::entry_t            ent_upd;
  tssm_pkg::ev_t               ev;

  logic                        out_ev_valid;
  tssm_pkg::ev_t               out_ev;

  assign q_idx   = q_item.slot[tssm_pkg::SLOT_IDX_W-1:0];
  assign cur_idx = cur.slot[tssm_pkg::SLOT_IDX_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tssm_pkg::BK_IDLE: begin
        if (!q_stat.empty) state_next = tssm_pkg::BK_LOOKUP;
      end
      tssm_pkg::BK_LOOKUP: begin
        if (cur.kind == tssm_pkg::KIND_TRACK) begin
          state_next = tssm_pkg::BK_DIVIDE;
        end else begin
          state_next = tssm_pkg::BK_FINISH;
        end
      end
      tssm_pkg::BK_DIVIDE: begin
        if (div_done) state_next = tssm_pkg::BK_EVENT;
      end
      tssm_pkg::BK_EVENT: begin
        state_next = tssm_pkg::BK_FINISH;
      end
      tssm_pkg::BK_FINISH: begin
        if (!out_ev_valid || out_ready) state_next = tssm_pkg::BK_IDLE;
      end
      default: begin
        state_next = tssm_pkg::BK_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    pop       = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    clr_valid = 1'b0;
    out_load  = 1'b0;
    case (state)
      tssm_pkg::BK_IDLE: begin
        pop    = !q_stat.empty;
        mem_re = !q_stat.empty;
      end
      tssm_pkg::BK_LOOKUP: begin
        div_start = cur.kind == tssm_pkg::KIND_TRACK;
        clr_valid = cur.kind == tssm_pkg::KIND_CLEAR;
      end
      tssm_pkg::BK_EVENT: begin
        mem_we = 1'b1;
      end
      tssm_pkg::BK_FINISH: begin
        out_load = !out_ev_valid || out_ready;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tssm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Resolve the entry: new task, progress, or unchanged
  always_comb begin
    hit = entry_valid[cur_idx] && (rd_data.start == cur.start);
    if (!hit) begin
      ent_new.start      = cur.start;
      ent_new.scope      = cur.scope;
      ent_new.progress   = cur.start;
      ent_new.stall_done = 1'b0;
      ent_new.slow_done  = 1'b0;
    end else if (rd_data.scope != cur.scope) begin
      ent_new.start      = rd_data.start;
      ent_new.scope      = cur.scope;
      ent_new.progress   = cur.now;
      ent_new.stall_done = 1'b0;
      ent_new.slow_done  = rd_data.slow_done;
    end else begin
      ent_new = rd_data;
    end
    // Saturate time running backwards to zero
    run_diff  = (cur.now >= cur.start) ? cur.now - cur.start : '0;
    idle_diff = (cur.now >= ent_new.progress) ? cur.now - ent_new.progress : '0;
  end

  tssm_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .dvd_a  (run_diff),
    .dvd_b  (idle_diff),
    .done   (div_done),
    .quot_a (quot_run),
    .quot_b (quot_idle)
  );

  // Decide the event; a stall also retires the slow report
  always_comb begin
    stall_hit = (quot_idle >= tssm_pkg::MS_W'(stall_limit)) && !ent.stall_done
                && !cur.stall_exempt;
    slow_hit  = !stall_hit && (quot_run >= tssm_pkg::MS_W'(slow_limit))
                && !ent.slow_done && !cur.slow_exempt;
    ent_upd = ent;
    if (stall_hit) begin
      ent_upd.stall_done = 1'b1;
      ent_upd.slow_done  = 1'b1;
    end
    if (slow_hit) begin
      ent_upd.slow_done = 1'b1;
    end
    if (stall_hit) begin
      ev = tssm_pkg::EV_STALL;
    end else if (slow_hit) begin
      ev = tssm_pkg::EV_SLOW;
    end else begin
      ev = tssm_pkg::EV_NONE;
    end
  end

  // Slot table: one read, one write
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= table_mem[q_idx];
    end
    if (mem_we) begin
      table_mem[cur_idx] <= ent_upd;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (clr_valid) begin
      entry_valid[cur_idx] <= 1'b0;
    end else if (mem_we) begin
      entry_valid[cur_idx] <= 1'b1;
    end
  end

  // Working item, entry and result
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_item;
    end
    if (state == tssm_pkg::BK_LOOKUP) begin
      ent      <= ent_new;
      res_ev   <= tssm_pkg::EV_NONE;
      res_run  <= '0;
      res_idle <= '0;
      res_hp   <= (cur.kind == tssm_pkg::KIND_TRACK) && (ent_new.progress != cur.start);
    end
    if (state == tssm_pkg::BK_EVENT) begin
      res_ev   <= ev;
      res_run  <= quot_run;
      res_idle <= quot_idle;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ev       <= res_ev;
      slot_out     <= cur.slot;
      running_ms   <= res_run;
      idle_ms      <= res_idle;
      had_progress <= res_hp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ev_valid <= 1'b0;
    end else if (out_load) begin
      out_ev_valid <= 1'b1;
    end else if (out_ready) begin
      out_ev_valid <= 1'b0;
    end
  end

  assign out_valid = out_ev_valid;
  assign event_res = out_ev;

endmodule

FILE: sv/task_stall_slow_monitor.sv
// Top level of the task stall/slow monitor: config registers and the front/back split.
// Depends on tssm_pkg, tssm_front, tssm_fifo, tssm_back.
//
//   channel   handshake             payload
//   in        in_valid / in_ready   thread_slot, task_active, task_start, scope_tag,
//                                   now_time, stall_exempt, slow_exempt
//   out       out_valid / out_ready event_res, slot_out, running_ms, idle_ms,
//                                   had_progress
//   config    APB psel/penable      paddr, pwdata, prdata, pready
//
// An active report passes through the back end in this order: pop, lookup, the
// four-step reciprocal multiply that divides by one million, event decision with
// write back, and result load. Other reports go from lookup straight to result load.
// The front takes words while a two-deep queue has room, and the result register
// holds a finished word while out_ready is low.
// Synchronous reset clears the slot valid bits, the queue and both handshakes.
module task_stall_slow_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tssm_pkg::SLOT_W-1:0]   thread_slot,
  input  logic                          task_active,
  input  logic [tssm_pkg::TIME_W-1:0]   task_start,
  input  logic [tssm_pkg::SCOPE_W-1:0]  scope_tag,
  input  logic [tssm_pkg::TIME_W-1:0]   now_time,
  input  logic                          stall_exempt,
  input  logic                          slow_exempt,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tssm_pkg::EV_W-1:0]     event_res,
  output logic [tssm_pkg::SLOT_W-1:0]   slot_out,
  output logic [tssm_pkg::MS_W-1:0]     running_ms,
  output logic [tssm_pkg::MS_W-1:0]     idle_ms,
  output logic                          had_progress,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tssm_pkg::PADDR_W-1:0]  paddr,
  input  logic [tssm_pkg::PDATA_W-1:0]  pwdata,
  output logic [tssm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic [tssm_pkg::LIMIT_W-1:0] stall_limit_ms;
  logic [tssm_pkg::LIMIT_W-1:0] slow_limit_ms;
  logic                         reg_wr;
  logic                         reg_sel;

  logic                push;
  logic                pop;
  tssm_pkg::item_t     push_item;
  tssm_pkg::item_t     pop_item;
  tssm_pkg::q_status_t q_stat;

  // Register file: word select on address bit 2
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stall_limit_ms <= tssm_pkg::STALL_LIMIT_RST;
      slow_limit_ms  <= tssm_pkg::SLOW_LIMIT_RST;
    end else if (reg_wr) begin
      if (reg_sel == tssm_pkg::REG_STALL_LIMIT) begin
        stall_limit_ms <= pwdata;
      end else begin
        slow_limit_ms <= pwdata;
      end
    end
  end

  assign prdata = (reg_sel == tssm_pkg::REG_SLOW_LIMIT) ? slow_limit_ms : stall_limit_ms;

  tssm_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .thread_slot  (thread_slot),
    .task_active  (task_active),
    .task_start   (task_start),
    .scope_tag    (scope_tag),
    .now_time     (now_time),
    .stall_exempt (stall_exempt),
    .slow_exempt  (slow_exempt),
    .q_stat       (q_stat),
    .push         (push),
    .push_item    (push_item)
  );

  tssm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  tssm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_item       (pop_item),
    .q_stat       (q_stat),
    .pop          (pop),
    .stall_limit  (stall_limit_ms),
    .slow_limit   (slow_limit_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_res    (event_res),
    .slot_out     (slot_out),
    .running_ms   (running_ms),
    .idle_ms      (idle_ms),
    .had_progress (had_progress)
  );

endmodule

FILE: sv/tssm_chk.sv
// Port-level checker for the task stall/slow monitor, bound to the top level.
// Depends on tssm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tssm_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tssm_pkg::EV_W-1:0]   event_res,
  input logic [tssm_pkg::SLOT_W-1:0] slot_out,
  input logic [tssm_pkg::MS_W-1:0]   running_ms,
  input logic [tssm_pkg::MS_W-1:0]   idle_ms,
  input logic                        had_progress
);

  // A stalled result holds its word
  `TSSM_ASSERT_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(slot_out) && $stable(running_ms) && $stable(idle_ms) && $stable(had_progress), "result word changed while stalled")

  // Without progress the idle clock is the run clock
  `TSSM_ASSERT_RST(a_no_progress_idle, clk, rst, out_valid && !had_progress |-> idle_ms == running_ms, "idle_ms differs from running_ms without progress")

  // An event word always carries a known event code, stall or slow
  `TSSM_ASSERT_RST(a_event_code, clk, rst, out_valid && event_res != tssm_pkg::EV_NONE |-> event_res == tssm_pkg::EV_STALL || event_res == tssm_pkg::EV_SLOW, "unknown event code")

  // Reset drops the result
  `TSSM_ASSERT(a_rst_clears, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind task_stall_slow_monitor tssm_chk u_tssm_chk (.*);

FILE: dv/task_stall_slow_monitor_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the task stall/slow monitor: sequenced slot reports,
// APB limit changes and random backpressure. Depends on tssm_pkg and the RTL.
module task_stall_slow_monitor_tb;

  localparam int IDLE_CYCLES_MAX = 5000;
  localparam logic [tssm_pkg::TIME_W-1:0] TIME_MAX = {tssm_pkg::TIME_W{1'b1}};

  typedef struct packed {
    tssm_pkg::ev_t               ev;
    logic [tssm_pkg::SLOT_W-1:0] slot;
    logic [tssm_pkg::MS_W-1:0]   run_ms;
    logic [tssm_pkg::MS_W-1:0]   idle_ms;
    logic                        progressed;
  } watch_event_t;

  // Shadow of the slot table; predicts one event word per accepted report
  class stall_event_scoreboard;
    logic [tssm_pkg::LIMIT_W-1:0] stall_lim;
    logic [tssm_pkg::LIMIT_W-1:0] slow_lim;
    bit                           tracked[tssm_pkg::NUM_SLOTS];
    logic [tssm_pkg::TIME_W-1:0]  t_start[tssm_pkg::NUM_SLOTS];
    logic [tssm_pkg::TIME_W-1:0]  t_progress[tssm_pkg::NUM_SLOTS];
    logic [tssm_pkg::SCOPE_W-1:0] t_scope[tssm_pkg::NUM_SLOTS];
    bit                           stall_seen[tssm_pkg::NUM_SLOTS];
    bit                           slow_seen[tssm_pkg::NUM_SLOTS];
    watch_event_t                 pending_q[$];
    int                           errors;
    int                           results;

    function new();
      stall_lim = tssm_pkg::STALL_LIMIT_RST;
      slow_lim  = tssm_pkg::SLOW_LIMIT_RST;
      foreach (tracked[i]) tracked[i] = 0;
      errors  = 0;
      results = 0;
    endfunction

    // Whole milliseconds between two times; zero when time runs backwards
    function logic [tssm_pkg::MS_W-1:0] ms_span(logic [tssm_pkg::TIME_W-1:0] from,
                                                logic [tssm_pkg::TIME_W-1:0] upto);
      if (upto < from) return '0;
      return tssm_pkg::MS_W'((upto - from) / tssm_pkg::TIME_W'(tssm_pkg::NS_PER_MS));
    endfunction

    function void set_limit(logic sel, logic [tssm_pkg::PDATA_W-1:0] value);
      if (sel == tssm_pkg::REG_STALL_LIMIT) stall_lim = value;
      else slow_lim = value;
    endfunction

    function void check_limit(logic sel, logic [tssm_pkg::PDATA_W-1:0] value);
      logic [tssm_pkg::LIMIT_W-1:0] want;
      want = (sel == tssm_pkg::REG_STALL_LIMIT) ? stall_lim : slow_lim;
      if (value !== want) begin
        errors++;
        $display("%0t limit readback sel %0d: expected %0d, actual %0d",
                 $time, sel, want, value);
      end
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction

    function void note_report(logic [tssm_pkg::SLOT_W-1:0] slot, logic act,
                              logic [tssm_pkg::TIME_W-1:0] st,
                              logic [tssm_pkg::SCOPE_W-1:0] sc,
                              logic [tssm_pkg::TIME_W-1:0] nw,
                              logic sx, logic lx);
      watch_event_t e;
      int s;
      e.ev = tssm_pkg::EV_NONE;
      e.slot = slot;
      e.run_ms = '0;
      e.idle_ms = '0;
      e.progressed = 1'b0;
      s = int'(slot);
      if (s < tssm_pkg::NUM_SLOTS) begin
        if (!act) begin
          tracked[s] = 0;
        end else begin
          // Replace the entry on a new task, advance progress on a scope change
          if (!tracked[s] || t_start[s] != st) begin
            tracked[s]    = 1;
            t_start[s]    = st;
            t_scope[s]    = sc;
            t_progress[s] = st;
            stall_seen[s] = 0;
            slow_seen[s]  = 0;
          end else if (t_scope[s] != sc) begin
            t_scope[s]    = sc;
            t_progress[s] = nw;
            stall_seen[s] = 0;
          end
          e.run_ms  = ms_span(st, nw);
          e.idle_ms = ms_span(t_progress[s], nw);
          // A stall wins and also retires the slow report
          if (e.idle_ms >= tssm_pkg::MS_W'(stall_lim) && !stall_seen[s] && !sx) begin
            stall_seen[s] = 1;
            slow_seen[s]  = 1;
            e.ev = tssm_pkg::EV_STALL;
          end else if (e.run_ms >= tssm_pkg::MS_W'(slow_lim) && !slow_seen[s] && !lx) begin
            slow_seen[s] = 1;
            e.ev = tssm_pkg::EV_SLOW;
          end
          e.progressed = (t_progress[s] != st);
        end
      end
      pending_q = {pending_q, e};
    endfunction

    function void check_event(logic [tssm_pkg::EV_W-1:0] ev,
                              logic [tssm_pkg::SLOT_W-1:0] slot,
                              logic [tssm_pkg::MS_W-1:0] run,
                              logic [tssm_pkg::MS_W-1:0] idl, logic prog);
      watch_event_t e;
      results++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t unexpected word: slot %0d event %0d", $time, slot, ev);
        return;
      end
      e = pending_q.pop_front();
      if (ev !== e.ev) begin
        errors++;
        $display("%0t event_res: expected %0d, actual %0d", $time, e.ev, ev);
      end
      if (slot !== e.slot) begin
        errors++;
        $display("%0t slot_out: expected %0d, actual %0d", $time, e.slot, slot);
      end
      if (run !== e.run_ms) begin
        errors++;
        $display("%0t running_ms: expected %0d, actual %0d", $time, e.run_ms, run);
      end
      if (idl !== e.idle_ms) begin
        errors++;
        $display("%0t idle_ms: expected %0d, actual %0d", $time, e.idle_ms, idl);
      end
      if (prog !== e.progressed) begin
        errors++;
        $display("%0t had_progress: expected %0d, actual %0d", $time, e.progressed, prog);
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [tssm_pkg::SLOT_W-1:0]   thread_slot;
  logic                          task_active;
  logic [tssm_pkg::TIME_W-1:0]   task_start;
  logic [tssm_pkg::SCOPE_W-1:0]  scope_tag;
  logic [tssm_pkg::TIME_W-1:0]   now_time;
  logic                          stall_exempt;
  logic                          slow_exempt;
  logic                          out_valid;
  logic                          out_ready;
  logic [tssm_pkg::EV_W-1:0]     event_res;
  logic [tssm_pkg::SLOT_W-1:0]   slot_out;
  logic [tssm_pkg::MS_W-1:0]     running_ms;
  logic [tssm_pkg::MS_W-1:0]     idle_ms;
  logic                          had_progress;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [tssm_pkg::PADDR_W-1:0]  paddr;
  logic [tssm_pkg::PDATA_W-1:0]  pwdata;
  logic [tssm_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  stall_event_scoreboard sb = new();

  // Limits as the stimulus side knows them
  logic [tssm_pkg::LIMIT_W-1:0] cfg_stall;
  logic [tssm_pkg::LIMIT_W-1:0] cfg_slow;

  // Per-slot task sequences for well-formed reports
  bit                           gen_live[tssm_pkg::NUM_SLOTS];
  logic [tssm_pkg::TIME_W-1:0]  gen_start[tssm_pkg::NUM_SLOTS];
  logic [tssm_pkg::TIME_W-1:0]  gen_now[tssm_pkg::NUM_SLOTS];
  logic [tssm_pkg::TIME_W-1:0]  gen_prog[tssm_pkg::NUM_SLOTS];
  logic [tssm_pkg::SCOPE_W-1:0] gen_scope[tssm_pkg::NUM_SLOTS];
  int                           prev_slot;

  task_stall_slow_monitor uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both channels and the register port at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_report(thread_slot, task_active, task_start, scope_tag, now_time,
                       stall_exempt, slow_exempt);
      if (out_valid && out_ready)
        sb.check_event(event_res, slot_out, running_ms, idle_ms, had_progress);
      if (psel && penable && pwrite && pready)
        sb.set_limit(paddr[2], pwdata);
    end
  end

  // End the run when no word moves for too long
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_CYCLES_MAX) begin
        $display("%0t no word accepted for %0d cycles", $time, quiet);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: switch among stall patterns, with one long hold-off
  initial begin : result_sink
    int mode;
    int left;
    int cnt;
    int on_len;
    int off_len;
    int hold_left;
    bit held;
    out_ready = 1'b0;
    mode = 0;
    left = 0;
    cnt = 0;
    on_len = 1;
    off_len = 1;
    hold_left = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (!held && sb.results >= 400) begin
        held = 1;
        hold_left = 800;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 300);
        on_len = $urandom_range(1, 8);
        off_len = $urandom_range(1, 12);
      end
      left--;
      cnt++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 99) < 85);
          default: out_ready <= ((cnt % (on_len + off_len)) < on_len);
        endcase
      end
    end
  end

  function automatic logic [tssm_pkg::TIME_W-1:0] ms_ns(longint unsigned n);
    return tssm_pkg::TIME_W'(n * 64'd1000000);
  endfunction

  function automatic logic [tssm_pkg::TIME_W-1:0] rand63();
    return tssm_pkg::TIME_W'({$urandom, $urandom});
  endfunction

  function automatic logic [tssm_pkg::TIME_W-1:0] step_ns(logic [tssm_pkg::LIMIT_W-1:0] lim);
    return ms_ns($urandom_range(0, lim / 3 + 1)) + tssm_pkg::TIME_W'($urandom_range(0, 999999));
  endfunction

  // Offer one report word and hold it until accepted
  task automatic send_word(logic [tssm_pkg::SLOT_W-1:0] slot, logic act,
                           logic [tssm_pkg::TIME_W-1:0] st,
                           logic [tssm_pkg::SCOPE_W-1:0] sc,
                           logic [tssm_pkg::TIME_W-1:0] nw,
                           logic sx, logic lx);
    @(negedge clk);
    in_valid     <= 1'b1;
    thread_slot  <= slot;
    task_active  <= act;
    task_start   <= st;
    scope_tag    <= sc;
    now_time     <= nw;
    stall_exempt <= sx;
    slow_exempt  <= lx;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_for(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding event word
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic reg_write(logic sel, logic [tssm_pkg::PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tssm_pkg::PADDR_W'({sel, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == tssm_pkg::REG_STALL_LIMIT) cfg_stall = value;
    else cfg_slow = value;
  endtask

  task automatic reg_read(logic sel);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= tssm_pkg::PADDR_W'({sel, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_limit(sel, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Edge cases under the reset limits (stall 60000 ms, slow 10000 ms)
  task automatic directed_reports();
    send_word(6'd0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    send_word(6'd1, 1'b1, '0, '0, '0, 1'b0, 1'b0);
    send_word(6'd1, 1'b1, '0, '0, ms_ns(10000), 1'b0, 1'b0);
    send_word(6'd1, 1'b1, '0, '0, ms_ns(10001), 1'b0, 1'b0);
    send_word(6'd1, 1'b1, '0, '0, ms_ns(60000), 1'b0, 1'b0);
    // progress re-arms the stall report
    send_word(6'd1, 1'b1, '0, 64'd7, ms_ns(61000), 1'b0, 1'b0);
    send_word(6'd1, 1'b1, '0, 64'd7, ms_ns(121000), 1'b0, 1'b0);
    // stall on first sight hides the slow report
    send_word(6'd2, 1'b1, '0, 64'd3, ms_ns(60000), 1'b0, 1'b0);
    send_word(6'd2, 1'b1, '0, 64'd3, ms_ns(70000), 1'b0, 1'b0);
    // exemption flags
    send_word(6'd3, 1'b1, '0, 64'd1, ms_ns(60000) - 1, 1'b0, 1'b1);
    send_word(6'd3, 1'b1, '0, 64'd1, ms_ns(60000), 1'b1, 1'b0);
    // time going backwards
    send_word(6'd4, 1'b1, ms_ns(100), 64'd9, ms_ns(50), 1'b0, 1'b0);
    send_word(6'd4, 1'b1, ms_ns(100), 64'd10, ms_ns(40), 1'b0, 1'b0);
    send_word(6'd4, 1'b1, ms_ns(100), 64'd10, ms_ns(30), 1'b0, 1'b0);
    // extremes of the time and scope fields
    send_word(6'd5, 1'b1, TIME_MAX, '1, TIME_MAX, 1'b0, 1'b0);
    send_word(6'd5, 1'b1, '0, '1, TIME_MAX, 1'b0, 1'b0);
    send_word(6'd63, 1'b1, TIME_MAX, '0, '0, 1'b1, 1'b1);
    send_word(6'd63, 1'b0, TIME_MAX, '1, TIME_MAX, 1'b1, 1'b1);
    send_word(6'd63, 1'b1, TIME_MAX, '1, TIME_MAX, 1'b0, 1'b0);
    send_word(6'd1, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    // back-to-back words on one slot
    send_word(6'd6, 1'b1, '0, 64'd1, '0, 1'b0, 1'b0);
    send_word(6'd6, 1'b1, '0, 64'd2, ms_ns(5), 1'b0, 1'b0);
    send_word(6'd6, 1'b1, '0, 64'd2, ms_ns(60005), 1'b0, 1'b0);
  endtask

  // Mostly well-formed task sequences, some inactive reports and raw noise
  task automatic send_random();
    int s;
    int r;
    int k;
    logic [tssm_pkg::TIME_W-1:0]  st;
    logic [tssm_pkg::TIME_W-1:0]  nw;
    logic [tssm_pkg::SCOPE_W-1:0] sc;
    logic [tssm_pkg::LIMIT_W-1:0] lim;
    logic act;
    logic sx;
    logic lx;
    s = ($urandom_range(0, 99) < 35) ? prev_slot : $urandom_range(0, tssm_pkg::NUM_SLOTS - 1);
    r = $urandom_range(0, 99);
    lim = $urandom_range(0, 1) ? cfg_stall : cfg_slow;
    sx = ($urandom_range(0, 9) == 0);
    lx = ($urandom_range(0, 9) == 0);
    act = 1'b1;
    if (r < 12) begin
      s = $urandom_range(0, tssm_pkg::NUM_SLOTS - 1);
      act = 1'($urandom_range(0, 1));
      st = rand63();
      sc = {$urandom, $urandom};
      nw = rand63();
      gen_live[s] = 0;
    end else if (r < 20) begin
      act = 1'b0;
      st = rand63();
      sc = {$urandom, $urandom};
      nw = rand63();
      gen_live[s] = 0;
    end else if (!gen_live[s] || r < 27) begin
      st = gen_now[s] + tssm_pkg::TIME_W'($urandom_range(0, 1000)) * 1000;
      sc = {$urandom, $urandom};
      nw = st + step_ns(lim);
      gen_live[s]  = 1;
      gen_start[s] = st;
      gen_scope[s] = sc;
      gen_prog[s]  = st;
    end else begin
      st = gen_start[s];
      sc = gen_scope[s];
      k = $urandom_range(0, 99);
      // land on the limits exactly or one nanosecond short now and then
      if (k < 6) nw = st + ms_ns(cfg_slow);
      else if (k < 10) nw = gen_prog[s] + ms_ns(cfg_stall);
      else if (k < 12) nw = st + ms_ns(cfg_slow) - 1;
      else if (k < 14) nw = gen_prog[s] + ms_ns(cfg_stall) - 1;
      else if (k < 17) nw = gen_now[s] - step_ns(lim);
      else nw = gen_now[s] + step_ns(lim);
      if ($urandom_range(0, 4) == 0) begin
        sc = {$urandom, $urandom};
        gen_scope[s] = sc;
        gen_prog[s]  = nw;
      end
    end
    gen_now[s] = nw;
    prev_slot = s;
    send_word(tssm_pkg::SLOT_W'(s), act, st, sc, nw, sx, lx);
  endtask

  // Set both limits while idle, then offer words in bursts
  task automatic run_phase(logic [tssm_pkg::LIMIT_W-1:0] stall_ms,
                           logic [tssm_pkg::LIMIT_W-1:0] slow_ms, int count);
    int burst;
    int gap;
    drain();
    reg_write(tssm_pkg::REG_STALL_LIMIT, stall_ms);
    reg_write(tssm_pkg::REG_SLOW_LIMIT, slow_ms);
    reg_read(tssm_pkg::REG_STALL_LIMIT);
    reg_read(tssm_pkg::REG_SLOW_LIMIT);
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap > 0) idle_for(gap);
        burst = $urandom_range(1, 40);
      end
      send_random();
      burst--;
    end
  endtask

  initial begin : stimulus
    rst          = 1'b1;
    in_valid     = 1'b0;
    thread_slot  = '0;
    task_active  = 1'b0;
    task_start   = '0;
    scope_tag    = '0;
    now_time     = '0;
    stall_exempt = 1'b0;
    slow_exempt  = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    cfg_stall    = tssm_pkg::STALL_LIMIT_RST;
    cfg_slow     = tssm_pkg::SLOW_LIMIT_RST;
    prev_slot    = 0;
    for (int i = 0; i < tssm_pkg::NUM_SLOTS; i++) begin
      gen_live[i] = 0;
      gen_now[i]  = rand63() >> 2;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    reg_read(tssm_pkg::REG_STALL_LIMIT);
    reg_read(tssm_pkg::REG_SLOW_LIMIT);
    directed_reports();

    run_phase(tssm_pkg::STALL_LIMIT_RST, tssm_pkg::SLOW_LIMIT_RST, 150);
    run_phase(32'd50, 32'd20, 400);
    run_phase(32'd20, 32'd50, 300);
    run_phase(32'd0, 32'd0, 150);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 150);
    run_phase(32'd1, 32'hFFFF_FFFF, 150);
    run_phase(32'hFFFF_FFFF, 32'd1, 150);

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      if (sb.outstanding() != 0)
        $display("%0t %0d event words never arrived", $time, sb.outstanding());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
